### hdl/esc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the elevator scan controller: motor codes,
// field widths and the packing of the stream beats.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Floors that the 5-bit button and sensor fields can report
    localparam int IN_BITS = 5;

    // Field widths
    localparam int FLOOR_W = 3;
    localparam int MOTOR_W = 2;

    // Stream beat widths (rounded up to whole bytes)
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Motor command codes
    typedef enum logic [MOTOR_W-1:0] {
        MOTOR_OFF   = 2'd0,
        MOTOR_UP    = 2'd1,
        MOTOR_DOWN  = 2'd2,
        MOTOR_BRAKE = 2'd3
    } motor_t;

endpackage : esc_pkg
`default_nettype wire

### hdl/elevator_scan_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elevator_scan_controller
// Lift controller that sweeps up and down over the floors, one tick per beat.
// ----------------------------------------------------------------------------
// Each input beat is one controller tick and carries the call buttons and the
// active-low floor sensors. The first tick after reset only picks up the car
// position from the highest asserted sensor (floor 0 when none is asserted).
// After that, while the car stands, each tick looks at one scan position of
// the current sweep and takes a pending call there; a call for another floor
// starts the motor, and each tick then checks the sensor of the next floor,
// braking when the target is reached. A sweep that runs off its end reverses
// and restarts from the car's floor. The block takes one beat per clock, as long
// as the result side keeps up, and returns exactly one result beat per input
// beat in the cycle after it; the rate is set by the combinational next-state
// logic between the controller state registers and the output register. The
// output register accepts a new beat while the previous result is being taken,
// so s_tready stays high as long as the result side keeps up.
// ----------------------------------------------------------------------------
module elevator_scan_controller
    import esc_pkg::*;
#(
    parameter int NUM_FLOORS = 5
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Tick input
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // [4:0] call_buttons, [9:5] floor_sensors_n
    // Result output
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata   // [1:0] motor_drive, [4:2] floor_now,
                                               // [5] sweep_up, [6] floor_changed,
                                               // [7] call_taken, [10:8] called_floor
);

    // Floors both reachable and visible on the 5-bit inputs
    localparam int LIVE_FLOORS = (NUM_FLOORS < IN_BITS) ? NUM_FLOORS : IN_BITS;
    localparam int CLOG_FLOORS = $clog2(NUM_FLOORS);
    localparam int SCAN_W      = (CLOG_FLOORS > FLOOR_W) ? CLOG_FLOORS : FLOOR_W;

    // Input fields
    logic [IN_BITS-1:0] call_buttons;
    logic [IN_BITS-1:0] floor_sensors_n;

    // Controller state
    logic               started_reg,  started_next;
    logic [FLOOR_W-1:0] car_floor_reg, car_floor_next;
    logic               going_up_reg, going_up_next;
    logic [SCAN_W-1:0]  scan_index_reg, scan_index_next;
    logic               moving_reg,   moving_next;
    logic [FLOOR_W-1:0] target_reg,   target_next;
    motor_t             drive_reg,    drive_next;

    // Per-tick results
    logic               changed;
    logic               taken;
    logic [FLOOR_W-1:0] called;
    logic               do_advance;

    // Helpers
    logic [FLOOR_W-1:0] top_floor;
    logic [FLOOR_W-1:0] next_floor;
    logic               head_up;
    logic               scan_live;
    logic               accept;

    // Output register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    assign call_buttons    = s_tdata[IN_BITS-1:0];
    assign floor_sensors_n = s_tdata[2*IN_BITS-1:IN_BITS];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Find the highest asserted sensor for the start-up tick
    always_comb begin
        top_floor = '0;
        for (int f = 0; f < IN_BITS; f++) begin
            if (f < LIVE_FLOORS && !floor_sensors_n[f]) begin
                top_floor = FLOOR_W'(f);
            end
        end
    end

    // Next floor toward the target
    assign head_up    = target_reg > car_floor_reg;
    assign next_floor = head_up ? car_floor_reg + FLOOR_W'(1) :
                        ((car_floor_reg == '0) ? '0 : car_floor_reg - FLOOR_W'(1));

    assign scan_live = int'(scan_index_reg) < LIVE_FLOORS;

    // Tick logic: start-up, travel or scan
    always_comb begin
        started_next   = started_reg;
        car_floor_next = car_floor_reg;
        moving_next    = moving_reg;
        target_next    = target_reg;
        drive_next     = drive_reg;
        changed        = 1'b0;
        taken          = 1'b0;
        called         = '0;
        do_advance     = 1'b0;

        if (!started_reg) begin
            started_next   = 1'b1;
            car_floor_next = top_floor;
            changed        = 1'b1;
        end else if (moving_reg) begin
            if (next_floor != car_floor_reg && int'(next_floor) < LIVE_FLOORS &&
                !floor_sensors_n[next_floor]) begin
                car_floor_next = next_floor;
                changed        = 1'b1;
                if (next_floor == target_reg) begin
                    drive_next  = MOTOR_BRAKE;
                    moving_next = 1'b0;
                    do_advance  = 1'b1;
                end
            end else if (next_floor == car_floor_reg) begin
                drive_next  = MOTOR_BRAKE;
                moving_next = 1'b0;
                do_advance  = 1'b1;
            end
        end else begin
            if (scan_live && call_buttons[scan_index_reg[FLOOR_W-1:0]]) begin
                taken  = 1'b1;
                called = scan_index_reg[FLOOR_W-1:0];
                if (scan_index_reg != SCAN_W'(car_floor_reg)) begin
                    target_next = scan_index_reg[FLOOR_W-1:0];
                    drive_next  = (scan_index_reg > SCAN_W'(car_floor_reg)) ?
                                  MOTOR_UP : MOTOR_DOWN;
                    moving_next = 1'b1;
                end else begin
                    do_advance = 1'b1;
                end
            end else begin
                do_advance = 1'b1;
            end
        end
    end

    // Advance the scan; reverse the sweep at either end
    always_comb begin
        going_up_next   = going_up_reg;
        scan_index_next = scan_index_reg;
        if (!started_reg) begin
            scan_index_next = SCAN_W'(top_floor);
        end else if (do_advance) begin
            if (going_up_reg) begin
                if (int'(scan_index_reg) + 1 >= NUM_FLOORS) begin
                    going_up_next   = 1'b0;
                    scan_index_next = SCAN_W'(car_floor_next);
                end else begin
                    scan_index_next = scan_index_reg + SCAN_W'(1);
                end
            end else begin
                if (scan_index_reg == '0) begin
                    going_up_next   = 1'b1;
                    scan_index_next = SCAN_W'(car_floor_next);
                end else begin
                    scan_index_next = scan_index_reg - SCAN_W'(1);
                end
            end
        end
    end

    // Hold the controller state; update it on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg    <= 1'b0;
            car_floor_reg  <= '0;
            going_up_reg   <= 1'b1;
            scan_index_reg <= '0;
            moving_reg     <= 1'b0;
            target_reg     <= '0;
            drive_reg      <= MOTOR_OFF;
        end else if (accept) begin
            started_reg    <= started_next;
            car_floor_reg  <= car_floor_next;
            going_up_reg   <= going_up_next;
            scan_index_reg <= scan_index_next;
            moving_reg     <= moving_next;
            target_reg     <= target_next;
            drive_reg      <= drive_next;
        end
    end

    // Output valid: set on accept, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {5'b0, called, taken, changed, going_up_next,
                           car_floor_next, drive_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    // A moving car always has a target other than its own floor
    assert property (@(posedge aclk) disable iff (!aresetn)
        moving_reg |-> (target_reg != car_floor_reg))
        else $error("moving with target at car floor");

    // A moving car drives the motor up or down
    assert property (@(posedge aclk) disable iff (!aresetn)
        moving_reg |-> (drive_reg == MOTOR_UP || drive_reg == MOTOR_DOWN))
        else $error("moving without drive");

    // Every accepted tick leaves a result waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted tick without result");

    // Called floor is zero unless a call was taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[7]) |-> (m_tdata[10:8] == '0))
        else $error("called floor without call");
`endif

endmodule : elevator_scan_controller
`default_nettype wire

### tb/elevator_scan_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_scan_controller_tb
// Self-checking bench for the sweeping lift controller.
// ----------------------------------------------------------------------------
// Each input beat is one controller tick. A scoreboard class carries its own
// model of the sweep: on every accepted tick it works out the result beat that
// the controller must return, and every result beat taken from the block is
// compared field by field with the oldest one waiting. The stimulus plays the
// part of the car: the floor sensors mostly follow the modeled car position,
// with the next floor's sensor asserting some ticks after a move starts, and
// the rest are random noise beats. Four pacing phases run in turn: no
// idling, a slow sender, a stalling receiver, and light idling on both sides.
// ----------------------------------------------------------------------------
module elevator_scan_controller_tb
    import esc_pkg::*;
;

    localparam int NUM_FLOORS = 5;
    localparam int RANDOM_TICKS = 1750;

    // Expected contents of one result beat
    typedef struct {
        motor_t               motor;
        logic [FLOOR_W-1:0]   floor_now;
        logic                 sweep_up;
        logic                 floor_changed;
        logic                 call_taken;
        logic [FLOOR_W-1:0]   called_floor;
    } lift_result_t;

    // Sweep model and store of expected result beats
    class lift_scoreboard;
        bit                 started;
        bit [FLOOR_W-1:0]   car_floor;
        bit                 going_up;
        bit [FLOOR_W-1:0]   scan_pos;
        bit                 moving;
        bit [FLOOR_W-1:0]   target_floor;
        motor_t             motor;
        lift_result_t       awaited[$];
        int                 mismatches;

        function new();
            started      = 1'b0;
            car_floor    = '0;
            going_up     = 1'b1;
            scan_pos     = '0;
            moving       = 1'b0;
            target_floor = '0;
            motor        = MOTOR_OFF;
            mismatches   = 0;
        endfunction

        // Floor the car reaches next on its way to the target
        function int next_stop();
            if (target_floor > car_floor) begin
                return int'(car_floor) + 1;
            end
            return (car_floor == 0) ? 0 : int'(car_floor) - 1;
        endfunction

        // Step the scan; reverse and restart from the car at a sweep end
        function void sweep_on();
            if (going_up) begin
                if (int'(scan_pos) + 1 >= NUM_FLOORS) begin
                    going_up = 1'b0;
                    scan_pos = car_floor;
                end else begin
                    scan_pos = scan_pos + 1'b1;
                end
            end else begin
                if (scan_pos == 0) begin
                    going_up = 1'b1;
                    scan_pos = car_floor;
                end else begin
                    scan_pos = scan_pos - 1'b1;
                end
            end
        endfunction

        // Advance the model by one accepted tick and queue its result
        function void note_tick(logic [IN_BITS-1:0] calls, logic [IN_BITS-1:0] sens_n);
            lift_result_t res;
            int top;
            int nxt;
            res.floor_changed = 1'b0;
            res.call_taken    = 1'b0;
            res.called_floor  = '0;
            if (!started) begin
                top = 0;
                for (int f = 0; f < IN_BITS; f++) begin
                    if (f < NUM_FLOORS && !sens_n[f]) top = f;
                end
                car_floor = top[FLOOR_W-1:0];
                scan_pos  = top[FLOOR_W-1:0];
                started   = 1'b1;
                res.floor_changed = 1'b1;
            end else if (moving) begin
                nxt = next_stop();
                if (nxt != car_floor && nxt < NUM_FLOORS && nxt < IN_BITS && !sens_n[nxt]) begin
                    car_floor = nxt[FLOOR_W-1:0];
                    res.floor_changed = 1'b1;
                    if (car_floor == target_floor) begin
                        motor  = MOTOR_BRAKE;
                        moving = 1'b0;
                        sweep_on();
                    end
                end else if (nxt == car_floor) begin
                    motor  = MOTOR_BRAKE;
                    moving = 1'b0;
                    sweep_on();
                end
            end else begin
                if (scan_pos < NUM_FLOORS && calls[scan_pos]) begin
                    res.call_taken   = 1'b1;
                    res.called_floor = scan_pos;
                    if (scan_pos != car_floor) begin
                        target_floor = scan_pos;
                        motor  = (scan_pos > car_floor) ? MOTOR_UP : MOTOR_DOWN;
                        moving = 1'b1;
                    end else begin
                        sweep_on();
                    end
                end else begin
                    sweep_on();
                end
            end
            res.motor     = motor;
            res.floor_now = car_floor;
            res.sweep_up  = going_up;
            awaited.push_back(res);
        endfunction

        task report(string field, int got, int want);
            if (mismatches < 100) begin
                $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, field, got, want);
            end
            mismatches++;
        endtask

        // Compare one result beat with the oldest expectation
        task check_result(logic [M_DATA_W-1:0] beat);
            lift_result_t want;
            if (awaited.size() == 0) begin
                report("result beat with none expected", int'(beat), 0);
            end else begin
                want = awaited.pop_front();
                if (beat[1:0] !== want.motor)
                    report("motor_drive", int'(beat[1:0]), int'(want.motor));
                if (beat[4:2] !== want.floor_now)
                    report("floor_now", int'(beat[4:2]), int'(want.floor_now));
                if (beat[5] !== want.sweep_up)
                    report("sweep_up", int'(beat[5]), int'(want.sweep_up));
                if (beat[6] !== want.floor_changed)
                    report("floor_changed", int'(beat[6]), int'(want.floor_changed));
                if (beat[7] !== want.call_taken)
                    report("call_taken", int'(beat[7]), int'(want.call_taken));
                if (beat[10:8] !== want.called_floor)
                    report("called_floor", int'(beat[10:8]), int'(want.called_floor));
                if (beat[M_DATA_W-1:11] !== '0)
                    report("padding", int'(beat[M_DATA_W-1:11]), 0);
            end
        endtask
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // [4:0] call_buttons, [9:5] floor_sensors_n
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // [1:0] motor_drive, [4:2] floor_now, [5] sweep_up,
                                         // [6] floor_changed, [7] call_taken, [10:8] called_floor

    int idle_pct = 0;
    int stall_pct = 0;
    lift_scoreboard sb = new();

    elevator_scan_controller #(
        .NUM_FLOORS(NUM_FLOORS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Check every result beat taken
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Send one tick beat, with random idle cycles ahead of it; call at a falling edge
    task send_tick(logic [IN_BITS-1:0] calls, logic [IN_BITS-1:0] sens_n);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - 2 * IN_BITS){1'b0}}, sens_n, calls};
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(calls, sens_n);
        @(negedge aclk);
    endtask

    function automatic logic [IN_BITS-1:0] at_floor(int f);
        return ~(5'd1 << f);
    endfunction

    function automatic logic [IN_BITS-1:0] pick_calls();
        int r;
        r = $urandom_range(9);
        if (r < 2) return '0;
        if (r < 5) return 5'd1 << $urandom_range(NUM_FLOORS - 1);
        return IN_BITS'($urandom_range(31));
    endfunction

    // Sensors as the car would show them, with some stray ones mixed in
    function automatic logic [IN_BITS-1:0] pick_sensors();
        int r;
        r = $urandom_range(99);
        if (!sb.moving) begin
            if (r < 85) return at_floor(sb.car_floor);
            return at_floor(sb.car_floor) & IN_BITS'($urandom_range(31));
        end
        if (r < 35) return at_floor(sb.next_stop());
        if (r < 65) return 5'h1f;
        if (r < 85) return at_floor(sb.car_floor);
        return IN_BITS'($urandom_range(31)) | ~at_floor(sb.next_stop());
    endfunction

    // Directed opening: first tick, own-floor call, sweep reversal, a full move
    task run_directed();
        int tries;
        send_tick(5'h1f, $urandom_range(1) ? 5'h1f : 5'b10100);
        send_tick(5'd1 << sb.scan_pos, at_floor(sb.car_floor));
        repeat (6) send_tick('0, at_floor(sb.car_floor));
        tries = 0;
        while (!sb.moving && tries < 5) begin
            send_tick(5'h1f & ~(5'd1 << sb.car_floor), at_floor(sb.car_floor));
            tries++;
        end
        tries = 0;
        while (sb.moving && tries < 5) begin
            send_tick(5'h1f, ~at_floor(sb.next_stop()) | at_floor(sb.car_floor));
            send_tick('0, at_floor(sb.next_stop()));
            tries++;
        end
        send_tick(5'h1f, '0);
        send_tick('0, 5'h1f);
    endtask

    task run_random(int count);
        repeat (count) begin
            if ($urandom_range(99) < 85) begin
                send_tick(pick_calls(), pick_sensors());
            end else begin
                send_tick(IN_BITS'($urandom_range(31)), IN_BITS'($urandom_range(31)));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        run_directed();
        idle_pct = 0;  stall_pct = 0;  run_random(RANDOM_TICKS / 4);
        idle_pct = 45; stall_pct = 0;  run_random(RANDOM_TICKS / 4);
        idle_pct = 0;  stall_pct = 45; run_random(RANDOM_TICKS / 4);
        idle_pct = 6;  stall_pct = 6;  run_random(RANDOM_TICKS / 4);
        s_tvalid <= 1'b0;
        // Drain outstanding results before the final report
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
